// ===== src/sblfr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the start-byte length-prefixed frame receiver
// no dependencies

package sblfr_pkg;

  localparam int DATA_W          = 8;
  localparam int POS_W           = 6;
  localparam int STORE_DEPTH     = 64;
  localparam int ADDR_W          = 6;
  localparam int COUNT_W         = 7;
  localparam int FLEN_W          = 9;

  localparam int FRAME_CAPACITY  = 64;
  localparam int HEADER_BYTES    = 3;
  localparam int LENGTH_POSITION = 2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

endpackage

// ===== src/sblfr_store.sv =====
`timescale 1ns / 1ps
// frame byte store: one write port, one read port with registered read data
// depends on sblfr_pkg

module sblfr_store (
  input  logic                         clk,
  input  sblfr_pkg::store_req_t        req,
  output logic [sblfr_pkg::DATA_W-1:0] rd_data
);

  logic [sblfr_pkg::DATA_W-1:0] mem [sblfr_pkg::STORE_DEPTH];
  logic [sblfr_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/start_byte_length_frame_receiver_core.sv =====
`timescale 1ns / 1ps
// start-byte length-prefixed frame receiver, top level
// depends on sblfr_pkg and sblfr_store
//
// Received bytes are taken one per cycle while no frame is being read out. A frame opens
// on the configured start byte; once the header is in, the length byte gives the frame
// length as payload + header + 1. A frame longer than FRAME_CAPACITY is dropped silently.
// A complete frame is read out of the byte store one beat per cycle, start
// byte first, with its position and a last mark; the input is held off from the beat
// that completes the frame until the last read is issued. Back-pressure on the output
// stalls the readout. The start byte register may be written at any time the block
// is idle.

module start_byte_length_frame_receiver_core #(
  parameter int FRAME_CAPACITY  = sblfr_pkg::FRAME_CAPACITY,
  parameter int HEADER_BYTES    = sblfr_pkg::HEADER_BYTES,
  parameter int LENGTH_POSITION = sblfr_pkg::LENGTH_POSITION
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sblfr_pkg::DATA_W-1:0] cfg_start_marker,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sblfr_pkg::DATA_W-1:0] in_data_byte,
  input  logic                         in_receive_enabled,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sblfr_pkg::DATA_W-1:0] out_frame_byte,
  output logic [sblfr_pkg::POS_W-1:0]  out_byte_position,
  output logic                         out_last_byte
);

  localparam int CW = sblfr_pkg::COUNT_W;
  localparam int FW = sblfr_pkg::FLEN_W;
  localparam int AW = sblfr_pkg::ADDR_W;

  localparam logic [CW-1:0] CAP_C  = CW'(FRAME_CAPACITY);
  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] LPOS_C = CW'(LENGTH_POSITION);
  localparam logic [FW-1:0] CAP_F  = FW'(FRAME_CAPACITY);
  localparam logic [FW-1:0] HDR_F  = FW'(HEADER_BYTES + 1);

  typedef enum logic {
    S_RECV,
    S_DUMP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [sblfr_pkg::DATA_W-1:0] marker_r;
  logic [CW-1:0]                held_r, held_nxt;
  logic [sblfr_pkg::DATA_W-1:0] len_r, len_nxt;
  logic [CW-1:0]                dump_len_r, dump_len_nxt;
  logic [CW-1:0]                rd_idx_r, rd_idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [sblfr_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                         last_r, last_nxt;

  sblfr_pkg::store_req_t        req;
  logic [sblfr_pkg::DATA_W-1:0] rd_data;

  logic          in_fire;
  logic          do_write;
  logic [CW-1:0] held_inc;
  logic [FW-1:0] flen;
  logic          rd_last;

  sblfr_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_RECV);
  assign in_fire   = in_valid && in_ready;

  assign do_write = in_fire && in_receive_enabled
                    && !(held_r == '0 && in_data_byte != marker_r)
                    && (held_r < CAP_C);
  assign held_inc = held_r + CW'(1);
  assign len_nxt  = (do_write && held_r == LPOS_C) ? in_data_byte : len_r;
  assign flen     = FW'(len_nxt) + HDR_F;
  assign rd_last  = (rd_idx_r + CW'(1)) == dump_len_r;

  always_comb begin
    req.wr_en   = do_write;
    req.wr_addr = held_r[AW-1:0];
    req.wr_data = in_data_byte;
    req.rd_en   = (state_r == S_DUMP) && (!out_valid_r || out_ready);
    req.rd_addr = rd_idx_r[AW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    dump_len_nxt  = dump_len_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;

    if (in_fire && in_receive_enabled && !(held_r == '0 && in_data_byte != marker_r)) begin
      if (held_r >= CAP_C) begin
        held_nxt = '0;
      end else if (held_inc < HDR_C) begin
        held_nxt = held_inc;
      end else if (flen > CAP_F) begin
        held_nxt = '0;
      end else if (FW'(held_inc) >= flen) begin
        held_nxt     = '0;
        dump_len_nxt = flen[CW-1:0];
        rd_idx_nxt   = '0;
        state_nxt    = S_DUMP;
      end else begin
        held_nxt = held_inc;
      end
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (req.rd_en) begin
      out_valid_nxt = 1'b1;
      pos_nxt       = rd_idx_r[sblfr_pkg::POS_W-1:0];
      last_nxt      = rd_last;
      rd_idx_nxt    = rd_idx_r + CW'(1);
      if (rd_last) begin
        state_nxt = S_RECV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RECV;
      marker_r    <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        marker_r <= cfg_start_marker;
      end
    end
    len_r      <= len_nxt;
    dump_len_r <= dump_len_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pos_r      <= pos_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = rd_data;
  assign out_byte_position = pos_r;
  assign out_last_byte     = last_r;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// testbench for start_byte_length_frame_receiver_core: directed and random byte streams
// with a frame predictor and a beat-by-beat scoreboard
// depends on sblfr_pkg and the receiver rtl

module tb;

  localparam int DATA_W          = sblfr_pkg::DATA_W;
  localparam int POS_W           = sblfr_pkg::POS_W;
  localparam int COUNT_W         = sblfr_pkg::COUNT_W;
  localparam int STORE_DEPTH     = sblfr_pkg::STORE_DEPTH;
  localparam int FRAME_CAPACITY  = sblfr_pkg::FRAME_CAPACITY;
  localparam int HEADER_BYTES    = sblfr_pkg::HEADER_BYTES;
  localparam int LENGTH_POSITION = sblfr_pkg::LENGTH_POSITION;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_PAYLOAD = FRAME_CAPACITY - HEADER_BYTES - 1;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              en;
  } rx_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] fbyte;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_start_marker = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic              in_receive_enabled = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_frame_byte;
  logic [POS_W-1:0]  out_byte_position;
  logic              out_last_byte;

  rx_item_t    byte_q[$];
  frame_beat_t frame_beats_due[$];

  logic [DATA_W-1:0]  rx_store [STORE_DEPTH];
  logic [COUNT_W-1:0] open_count;
  logic [DATA_W-1:0]  marker_model;
  logic [DATA_W-1:0]  stim_marker = '0;

  logic in_taken = 1'b0;
  int   send_idle_pct = 36;
  int   recv_idle_pct = 85;
  int   cfg_writes_seen = 0;
  int   err_count = 0;
  int   bytes_sent = 0;
  int   beats_checked = 0;
  int   frames_seen = 0;
  int   cycles = 0;

  start_byte_length_frame_receiver_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_start_marker   (cfg_start_marker),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_receive_enabled (in_receive_enabled),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_byte     (out_frame_byte),
    .out_byte_position  (out_byte_position),
    .out_last_byte      (out_last_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // frame tracking: one accepted byte, pushes the beats of a completed frame
  task automatic track_rx_byte(input logic [DATA_W-1:0] b, input logic en);
    int flen;
    frame_beat_t beat;
    if (!en) return;
    if (open_count == 0 && b != marker_model) return;
    if (open_count >= FRAME_CAPACITY) begin
      open_count = '0;
      return;
    end
    rx_store[open_count[POS_W-1:0]] = b;
    open_count = open_count + 1'b1;
    if (open_count < HEADER_BYTES) return;
    flen = int'(rx_store[LENGTH_POSITION]) + HEADER_BYTES + 1;
    if (flen > FRAME_CAPACITY) begin
      open_count = '0;
      return;
    end
    if (open_count < flen) return;
    for (int k = 0; k < flen; k++) begin
      beat.fbyte = rx_store[k];
      beat.pos   = k[POS_W-1:0];
      beat.last  = (k + 1 == flen);
      frame_beats_due.push_back(beat);
    end
    open_count = '0;
  endtask

  task automatic note_error(input string what, input frame_beat_t exp_b,
                            input frame_beat_t act_b);
    err_count++;
    if (err_count <= 10)
      $display("tb: %s expected byte %02h pos %0d last %0d, got byte %02h pos %0d last %0d",
               what, exp_b.fbyte, exp_b.pos, exp_b.last, act_b.fbyte, act_b.pos, act_b.last);
  endtask

  // sampling, prediction and checking
  always @(posedge clk) begin : monitor
    frame_beat_t act_b;
    frame_beat_t exp_b;
    if (!rst_n) begin
      open_count   = '0;
      marker_model = '0;
      in_taken     <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        marker_model = cfg_start_marker;
        cfg_writes_seen++;
      end
      if (in_valid && in_ready) begin
        bytes_sent++;
        track_rx_byte(in_data_byte, in_receive_enabled);
      end
      if (out_valid && out_ready) begin
        act_b = '{out_frame_byte, out_byte_position, out_last_byte};
        if (frame_beats_due.size() == 0) begin
          note_error("unexpected beat:", '0, act_b);
        end else begin
          exp_b = frame_beats_due.pop_front();
          beats_checked++;
          if (exp_b.last) frames_seen++;
          if (act_b != exp_b) note_error("beat mismatch:", exp_b, act_b);
        end
      end
    end
  end

  // input driver and output stall
  always @(negedge clk) begin : driver
    rx_item_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid           <= 1'b1;
        in_data_byte       <= nxt.data;
        in_receive_enabled <= nxt.en;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void put_byte(input logic [DATA_W-1:0] d, input logic en);
    byte_q.push_back('{d, en});
  endfunction

  // queues one frame; oversize frames stop after the header since they get dropped there
  task automatic queue_frame(input int plen, output int n);
    int total;
    n = 0;
    total = (plen > MAX_PAYLOAD) ? HEADER_BYTES : plen + HEADER_BYTES + 1;
    for (int i = 0; i < total; i++) begin
      if (i > 0 && $urandom_range(19) == 0) put_byte(8'($urandom), 1'b0);
      if (i == 0) put_byte(stim_marker, 1'b1);
      else if (i == LENGTH_POSITION) put_byte(plen[DATA_W-1:0], 1'b1);
      else put_byte(8'($urandom), 1'b1);
      n++;
    end
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || in_valid || frame_beats_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_marker(input logic [DATA_W-1:0] v);
    int seen;
    seen = cfg_writes_seen;
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_start_marker <= v;
    stim_marker = v;
    @(negedge clk);
    while (cfg_writes_seen == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_traffic(input int budget);
    int queued;
    int n;
    int sel;
    int plen;
    queued = 0;
    while (queued < budget) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        sel = $urandom_range(99);
        if (sel < 80) plen = $urandom_range(10);
        else if (sel < 88) plen = MAX_PAYLOAD;
        else plen = $urandom_range(MAX_PAYLOAD);
        queue_frame(plen, n);
        queued += n;
      end else if (sel < 80) begin
        queue_frame($urandom_range(255, MAX_PAYLOAD + 1), n);
        queued += n;
      end else if (sel < 90) begin
        // truncated frame, swallows part of whatever follows
        put_byte(stim_marker, 1'b1);
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) put_byte(8'($urandom), 1'b1);
        queued += n + 1;
      end else begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) put_byte(8'($urandom), 1'($urandom));
        queued += n;
      end
    end
  endtask

  initial begin
    logic [DATA_W-1:0] phase_marker [3];
    phase_marker = '{8'($urandom), 8'h00, 8'h80};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset marker of zero
    put_byte(8'h00, 1'b0);
    put_byte(8'h55, 1'b1);
    put_byte(8'h00, 1'b1); put_byte(8'hFF, 1'b1); put_byte(8'h00, 1'b1); put_byte(8'hAA, 1'b1);
    put_byte(8'h00, 1'b1); put_byte(8'h00, 1'b1); put_byte(8'h01, 1'b1);
    put_byte(8'h7E, 1'b0); put_byte(8'hFF, 1'b1); put_byte(8'h00, 1'b1);
    put_byte(8'h00, 1'b1); put_byte(8'h12, 1'b1); put_byte(8'h3D, 1'b1);
    put_byte(8'h00, 1'b1); put_byte(8'h34, 1'b1); put_byte(8'hFF, 1'b1);
    wait_idle();
    write_marker(8'hFF);
    put_byte(8'h00, 1'b1);
    put_byte(8'hFF, 1'b1); put_byte(8'h00, 1'b1); put_byte(8'h00, 1'b1); put_byte(8'h00, 1'b1);
    put_byte(8'hFF, 1'b1); put_byte(8'h80, 1'b1); put_byte(8'h02, 1'b1);
    put_byte(8'h01, 1'b1); put_byte(8'hFE, 1'b1); put_byte(8'h7F, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 36 : 0;
      write_marker(phase_marker[ph]);
      queue_random_traffic(65);
      wait_idle();
      queue_random_traffic(65);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    $display("tb: %0d bytes sent, %0d beats checked in %0d frames", bytes_sent,
             beats_checked, frames_seen);
    $display("tb: markers 00, ff and mid values, three stall mixes, drops and broken frames");
    if (frame_beats_due.size() != 0) begin
      err_count++;
      $display("tb: %0d expected beats never arrived", frame_beats_due.size());
    end
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
